// ===== src/content_hash_table_lookup_unit_macros.svh =====
// Assertion macros shared by the lookup unit modules.
`ifndef CONTENT_HASH_TABLE_LOOKUP_UNIT_MACROS_SVH
`define CONTENT_HASH_TABLE_LOOKUP_UNIT_MACROS_SVH
// Same-cycle implication, checked on every rising edge outside reset.
`define CHTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define CHTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/chtl_pkg.sv =====
// Types and constants of the content hash table lookup unit.
package chtl_pkg;

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] FNV_PRIME_LO = 64'h0000_0000_0000_01B3;
	localparam int unsigned FNV_PRIME_SHIFT = 40;

	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned CMD_CNT_W = 3;

	localparam logic REG_PACK_PRESENT = 1'b0;
	localparam logic REG_NAMES_SIZE = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_DATA = 2'd1,
		OP_RECORD = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_LOOKUP,
		CMD_RECORD
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_HIT = 3'd0,
		ST_UNAVAILABLE = 3'd1,
		ST_NO_MATCH = 3'd2,
		ST_OFFSET_RANGE = 3'd3,
		ST_FAILED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_BS_RD,
		BK_BS_CMP,
		BK_SC_RD,
		BK_SC_CMP,
		BK_FL_RD,
		BK_FL_CMP,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [63:0] hash;
		logic [31:0] length;
		logic [31:0] offset;
	} cmd_t;

	typedef struct packed {
		logic [63:0] hash;
		logic [31:0] length;
		logic [31:0] offset;
	} entry_t;

	// One FNV-1a 64 step; the prime is 2^40 + 0x1B3.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << FNV_PRIME_SHIFT) + x * FNV_PRIME_LO;
	endfunction

endpackage

// ===== src/chtl_front.sv =====
// Front end: hashes blob bytes and turns accepted items into commands.
module chtl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [1:0]         opcode,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic [63:0]        key_hash,
	input  logic [31:0]        key_length,
	input  logic [31:0]        name_offset,
	input  logic               cmd_full,
	output logic               full,
	output logic               cmd_wr,
	output chtl_pkg::cmd_t     cmd_wdata
);

	logic [63:0] hash_q;
	logic [31:0] len_q;
	logic [63:0] hash_next;
	logic [31:0] len_next;
	logic        accept;

	assign full = cmd_full;
	assign accept = push && !cmd_full;
	assign hash_next = chtl_pkg::fnv_step(hash_q, data_byte);
	assign len_next = (len_q == 32'hFFFF_FFFF) ? len_q : len_q + 32'd1;

	always_comb begin
		cmd_wr = 1'b0;
		cmd_wdata.kind = chtl_pkg::CMD_LOAD;
		cmd_wdata.hash = key_hash;
		cmd_wdata.length = key_length;
		cmd_wdata.offset = name_offset;
		if (accept) begin
			priority if (opcode == chtl_pkg::OP_LOAD) begin
				cmd_wr = 1'b1;
			end else if (opcode == chtl_pkg::OP_RECORD) begin
				cmd_wr = 1'b1;
				cmd_wdata.kind = chtl_pkg::CMD_RECORD;
			end else if (opcode == chtl_pkg::OP_DATA && last_byte) begin
				cmd_wr = 1'b1;
				cmd_wdata.kind = chtl_pkg::CMD_LOOKUP;
				cmd_wdata.hash = hash_next;
				cmd_wdata.length = len_next;
			end else begin
				// Inner bytes and the unused opcode queue nothing.
				cmd_wr = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= chtl_pkg::FNV_BASIS;
			len_q <= 32'd0;
		end else if (accept && opcode == chtl_pkg::OP_DATA) begin
			if (last_byte) begin
				hash_q <= chtl_pkg::FNV_BASIS;
				len_q <= 32'd0;
			end else begin
				hash_q <= hash_next;
				len_q <= len_next;
			end
		end
	end

endmodule

// ===== src/chtl_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
`include "content_hash_table_lookup_unit_macros.svh"
module chtl_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  chtl_pkg::cmd_t wdata,
	input  logic           rd,
	output logic           full,
	output logic           empty,
	output chtl_pkg::cmd_t rdata
);

	chtl_pkg::cmd_t mem_q [chtl_pkg::CMD_DEPTH];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [chtl_pkg::CMD_CNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == chtl_pkg::CMD_CNT_W'(chtl_pkg::CMD_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 2'd1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + chtl_pkg::CMD_CNT_W'(do_wr) - chtl_pkg::CMD_CNT_W'(do_rd);
		end
	end

	`CHTL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= chtl_pkg::CMD_CNT_W'(chtl_pkg::CMD_DEPTH), "command queue over capacity")
	`CHTL_ASSERT_NOW(a_no_wr_full, wr, !full, "command written while queue full")
	`CHTL_ASSERT_NEXT(a_wr_nonempty, do_wr && !do_rd, !empty, "queue empty after write")

endmodule

// ===== src/chtl_back.sv =====
// Back end: table and failed-list storage, binary search, scans and result register.
`include "content_hash_table_lookup_unit_macros.svh"
module chtl_back #(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned FAILED_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  chtl_pkg::cmd_t cmd,
	output logic           cmd_rd,
	input  logic           pack_present,
	input  logic [31:0]    names_size,
	input  logic           pop,
	output logic           empty,
	output logic [2:0]     status,
	output logic [31:0]    found_offset,
	output logic [63:0]    blob_hash,
	output logic [31:0]    blob_length
);

	localparam int unsigned TW = $clog2(TABLE_DEPTH);
	localparam int unsigned TCW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned FW = (FAILED_DEPTH > 1) ? $clog2(FAILED_DEPTH) : 1;
	localparam int unsigned FCW = $clog2(FAILED_DEPTH + 1);

	chtl_pkg::entry_t tmem [TABLE_DEPTH];
	logic [63:0] fmem [FAILED_DEPTH];
	chtl_pkg::entry_t trd_q;
	logic [63:0] frd_q;

	chtl_pkg::back_state_t state_q, state_d;
	logic [TCW-1:0] tcnt_q;
	logic [FCW-1:0] fcnt_q;
	logic [TCW-1:0] lo_q, hi_q, mid, lo_bs, hi_bs;
	logic [FCW-1:0] fidx_q;
	logic [63:0] hash_q;
	logic [31:0] len_q;
	logic [31:0] off_q;
	chtl_pkg::status_t st_q;

	logic out_valid_q;
	logic emit;
	logic [TW-1:0] t_ra;
	logic [FW-1:0] f_ra;
	logic t_we, f_we;
	logic unavail;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_bs = (trd_q.hash < hash_q) ? mid + TCW'(1) : lo_q;
	assign hi_bs = (trd_q.hash < hash_q) ? hi_q : mid;
	assign unavail = !pack_present || (tcnt_q == '0);
	assign emit = (state_q == chtl_pkg::BK_EMIT) && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chtl_pkg::BK_IDLE: begin
				if (!cmd_empty && cmd.kind == chtl_pkg::CMD_LOOKUP) begin
					state_d = unavail ? chtl_pkg::BK_EMIT : chtl_pkg::BK_BS_RD;
				end
			end
			chtl_pkg::BK_BS_RD: state_d = chtl_pkg::BK_BS_CMP;
			chtl_pkg::BK_BS_CMP: begin
				state_d = (lo_bs < hi_bs) ? chtl_pkg::BK_BS_RD : chtl_pkg::BK_SC_RD;
			end
			chtl_pkg::BK_SC_RD: begin
				state_d = (lo_q < tcnt_q) ? chtl_pkg::BK_SC_CMP : chtl_pkg::BK_EMIT;
			end
			chtl_pkg::BK_SC_CMP: begin
				priority if (trd_q.hash != hash_q) begin
					state_d = chtl_pkg::BK_EMIT;
				end else if (trd_q.length == len_q) begin
					state_d = ({32'd0, trd_q.offset} >= {32'd0, names_size}) ?
						chtl_pkg::BK_EMIT : chtl_pkg::BK_FL_RD;
				end else begin
					state_d = chtl_pkg::BK_SC_RD;
				end
			end
			chtl_pkg::BK_FL_RD: begin
				state_d = (fidx_q < fcnt_q) ? chtl_pkg::BK_FL_CMP : chtl_pkg::BK_EMIT;
			end
			chtl_pkg::BK_FL_CMP: begin
				state_d = (frd_q == hash_q) ? chtl_pkg::BK_EMIT : chtl_pkg::BK_FL_RD;
			end
			chtl_pkg::BK_EMIT: begin
				if (emit) begin
					state_d = chtl_pkg::BK_IDLE;
				end
			end
			default: state_d = chtl_pkg::BK_IDLE;
		endcase
	end

	// Memory strobes and queue pop.
	always_comb begin
		cmd_rd = 1'b0;
		t_we = 1'b0;
		f_we = 1'b0;
		t_ra = mid[TW-1:0];
		f_ra = fidx_q[FW-1:0];
		unique case (state_q)
			chtl_pkg::BK_IDLE: begin
				cmd_rd = !cmd_empty;
				t_we = !cmd_empty && cmd.kind == chtl_pkg::CMD_LOAD &&
					tcnt_q < TCW'(TABLE_DEPTH);
				f_we = !cmd_empty && cmd.kind == chtl_pkg::CMD_RECORD &&
					fcnt_q < FCW'(FAILED_DEPTH);
			end
			chtl_pkg::BK_SC_RD: t_ra = lo_q[TW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[tcnt_q[TW-1:0]] <= '{hash: cmd.hash, length: cmd.length, offset: cmd.offset};
		end
		trd_q <= tmem[t_ra];
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[fcnt_q[FW-1:0]] <= cmd.hash;
		end
		frd_q <= fmem[f_ra];
	end

	// Search datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			chtl_pkg::BK_IDLE: begin
				hash_q <= cmd.hash;
				len_q <= cmd.length;
				lo_q <= '0;
				hi_q <= tcnt_q;
				st_q <= chtl_pkg::ST_UNAVAILABLE;
			end
			chtl_pkg::BK_BS_CMP: begin
				lo_q <= lo_bs;
				hi_q <= hi_bs;
			end
			chtl_pkg::BK_SC_RD: st_q <= chtl_pkg::ST_NO_MATCH;
			chtl_pkg::BK_SC_CMP: begin
				if (trd_q.hash == hash_q && trd_q.length == len_q) begin
					st_q <= ({32'd0, trd_q.offset} >= {32'd0, names_size}) ?
						chtl_pkg::ST_OFFSET_RANGE : chtl_pkg::ST_HIT;
					off_q <= trd_q.offset;
					fidx_q <= '0;
				end else begin
					lo_q <= lo_q + TCW'(1);
				end
			end
			chtl_pkg::BK_FL_RD: st_q <= chtl_pkg::ST_HIT;
			chtl_pkg::BK_FL_CMP: begin
				if (frd_q == hash_q) begin
					st_q <= chtl_pkg::ST_FAILED;
				end
				fidx_q <= fidx_q + FCW'(1);
			end
			default: ;
		endcase
		if (emit) begin
			status <= st_q;
			found_offset <= (st_q == chtl_pkg::ST_HIT) ? off_q : 32'd0;
			blob_hash <= hash_q;
			blob_length <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chtl_pkg::BK_IDLE;
			tcnt_q <= '0;
			fcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (t_we) begin
				tcnt_q <= tcnt_q + TCW'(1);
			end
			if (f_we) begin
				fcnt_q <= fcnt_q + FCW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CHTL_ASSERT_NOW(a_tcnt_bound, 1'b1, tcnt_q <= TCW'(TABLE_DEPTH), "table count over capacity")
	`CHTL_ASSERT_NOW(a_bs_range, state_q == chtl_pkg::BK_BS_CMP, lo_q < hi_q && hi_q <= tcnt_q, "search window empty")
	`CHTL_ASSERT_NEXT(a_hit_in_range, emit && st_q == chtl_pkg::ST_HIT, found_offset < names_size, "hit offset out of range")
	`CHTL_ASSERT_NOW(a_no_write_busy, state_q != chtl_pkg::BK_IDLE, !t_we && !f_we && !cmd_rd, "store written during lookup")

endmodule

// ===== src/content_hash_table_lookup_unit.sv =====
// Content hash table lookup unit: FNV-1a 64 blob hashing and sorted table search.
// Data bytes are taken one per cycle while the command queue is not full; a non-final
// byte yields no result. A lookup runs a binary search, a scan of the equal-hash run and
// a scan of the failed list in the back end, each reading through the single registered
// read port of its store. A four-entry command queue lets bytes keep streaming while a
// lookup runs. Reset clears counts and the running hash.
module content_hash_table_lookup_unit #(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned FAILED_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// Item queue: a beat is taken when push is high and full is low.
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [63:0] key_hash,
	input  logic [31:0] key_length,
	input  logic [31:0] name_offset,
	// Result queue: a beat leaves when pop is high and empty is low.
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [31:0] found_offset,
	output logic [63:0] blob_hash,
	output logic [31:0] blob_length,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic           pack_present_q;
	logic [31:0]    names_size_q;
	logic           cmd_wr;
	logic           cmd_rd;
	logic           cmd_full;
	logic           cmd_empty;
	chtl_pkg::cmd_t cmd_wdata;
	chtl_pkg::cmd_t cmd_rdata;

	// Registers sit at byte addresses 0 and 4; bit 2 of the address selects one.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == chtl_pkg::REG_NAMES_SIZE) ? names_size_q :
		{31'd0, pack_present_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_present_q <= 1'b0;
			names_size_q <= 32'd0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == chtl_pkg::REG_PACK_PRESENT) begin
				pack_present_q <= pwdata[0];
			end else begin
				names_size_q <= pwdata;
			end
		end
	end

	// The front end folds each byte into the running hash in the cycle it is taken,
	// and only a final byte, a load or a failure record becomes a queued command.
	chtl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.key_hash    (key_hash),
		.key_length  (key_length),
		.name_offset (name_offset),
		.cmd_full    (cmd_full),
		.full        (full),
		.cmd_wr      (cmd_wr),
		.cmd_wdata   (cmd_wdata)
	);

	chtl_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd_wdata),
		.rd     (cmd_rd),
		.full   (cmd_full),
		.empty  (cmd_empty),
		.rdata  (cmd_rdata)
	);

	// The back end owns the table and the failed list and holds the result register,
	// so it can start the next command while the previous result waits to be taken.
	chtl_back #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.FAILED_DEPTH (FAILED_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (cmd_empty),
		.cmd          (cmd_rdata),
		.cmd_rd       (cmd_rd),
		.pack_present (pack_present_q),
		.names_size   (names_size_q),
		.pop          (pop),
		.empty        (empty),
		.status       (status),
		.found_offset (found_offset),
		.blob_hash    (blob_hash),
		.blob_length  (blob_length)
	);

endmodule

// ===== sim/tb_content_hash_table_lookup_unit.sv =====
// Self-checking testbench for the content hash table lookup unit.
`timescale 1ns / 100ps

module tb_content_hash_table_lookup_unit;

	localparam int unsigned TBL_DEPTH = 4096;
	localparam int unsigned FAIL_DEPTH = 4096;
	localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01B3;
	localparam logic [63:0] HASH_SEED = 64'hCBF2_9CE4_8422_2325;
	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam logic [2:0] ADDR_PACK = {chtl_pkg::REG_PACK_PRESENT, 2'b00};
	localparam logic [2:0] ADDR_NAMES = {chtl_pkg::REG_NAMES_SIZE, 2'b00};
	localparam int unsigned POOL_SIZE = 40;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  data;
		logic        last;
		logic [63:0] hash;
		logic [31:0] len;
		logic [31:0] off;
	} item_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] offset;
		logic [63:0] hash;
		logic [31:0] len;
	} lookup_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  opcode = '0;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic [63:0] key_hash = '0;
	logic [31:0] key_length = '0;
	logic [31:0] name_offset = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  status;
	logic [31:0] found_offset;
	logic [63:0] blob_hash;
	logic [31:0] blob_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	content_hash_table_lookup_unit dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .opcode(opcode), .data_byte(data_byte),
		.last_byte(last_byte), .key_hash(key_hash), .key_length(key_length),
		.name_offset(name_offset),
		.empty(empty), .pop(pop), .status(status), .found_offset(found_offset),
		.blob_hash(blob_hash), .blob_length(blob_length),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the unit: the record table, the failed list, the blob being
	// hashed and the two registers.
	logic [63:0] tbl_hash [TBL_DEPTH];
	logic [31:0] tbl_len [TBL_DEPTH];
	logic [31:0] tbl_off [TBL_DEPTH];
	int unsigned tbl_count = 0;
	logic [63:0] failed_list [FAIL_DEPTH];
	int unsigned failed_count = 0;
	logic [63:0] cur_hash = HASH_SEED;
	logic [31:0] cur_len = '0;
	logic        pack_on = 1'b0;
	logic [31:0] names_limit = '0;

	item_t   pending_items[$];
	lookup_t expected_lookups[$];
	item_t   cur_item;
	int      drv_gap = 0;
	int      pop_gap = 0;
	bit      quiet = 1'b0;
	int      errors = 0;
	int      checked = 0;
	int      status_seen [5];
	int      queued = 0;
	longint  cycles = 0;

	// Pool of short blobs whose hashes are loaded into the table.
	logic [7:0]  pool_bytes [POOL_SIZE][8];
	int          pool_len [POOL_SIZE];
	logic [63:0] pool_hash [POOL_SIZE];

	function automatic logic [63:0] hash_byte(input logic [63:0] h, input logic [7:0] b);
		return (h ^ {56'd0, b}) * HASH_PRIME;
	endfunction

	// Lowest entry with the blob hash, then the first of that run with equal length.
	function automatic int unsigned find_record(input logic [63:0] h, input logic [31:0] n);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_hash[mid] < h) lo = mid + 1;
			else hi = mid;
		end
		for (; lo < tbl_count && tbl_hash[lo] == h; lo++)
			if (tbl_len[lo] == n) return lo;
		return tbl_count;
	endfunction

	function automatic bit in_failed_list(input logic [63:0] h);
		for (int unsigned i = 0; i < failed_count; i++)
			if (failed_list[i] == h) return 1'b1;
		return 1'b0;
	endfunction

	// Advances the shadow state by one accepted beat and queues any lookup answer.
	task automatic model_item(input item_t it);
		lookup_t     res;
		int unsigned idx;
		case (it.op)
			chtl_pkg::OP_LOAD: begin
				if (tbl_count < TBL_DEPTH) begin
					tbl_hash[tbl_count] = it.hash;
					tbl_len[tbl_count] = it.len;
					tbl_off[tbl_count] = it.off;
					tbl_count++;
				end
			end
			chtl_pkg::OP_RECORD: begin
				if (failed_count < FAIL_DEPTH) begin
					failed_list[failed_count] = it.hash;
					failed_count++;
				end
			end
			chtl_pkg::OP_DATA: begin
				cur_hash = hash_byte(cur_hash, it.data);
				if (cur_len != 32'hFFFF_FFFF) cur_len++;
				if (it.last) begin
					res.offset = '0;
					if (!pack_on || tbl_count == 0) begin
						res.status = chtl_pkg::ST_UNAVAILABLE;
					end else begin
						idx = find_record(cur_hash, cur_len);
						if (idx >= tbl_count) res.status = chtl_pkg::ST_NO_MATCH;
						else if (tbl_off[idx] >= names_limit)
							res.status = chtl_pkg::ST_OFFSET_RANGE;
						else if (in_failed_list(cur_hash)) res.status = chtl_pkg::ST_FAILED;
						else begin
							res.status = chtl_pkg::ST_HIT;
							res.offset = tbl_off[idx];
						end
					end
					res.hash = cur_hash;
					res.len = cur_len;
					expected_lookups.push_back(res);
					cur_hash = HASH_SEED;
					cur_len = '0;
				end
			end
			default: ;
		endcase
	endtask

	// Item side: beats are taken from the pending queue, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			drv_gap = 0;
		end else begin
			if (push && !full) model_item(cur_item);
			if (push && full) begin
				// The current beat stays on the port until it is taken.
			end else if (drv_gap > 0) begin
				drv_gap--;
				push <= 1'b0;
			end else if (!quiet && pending_items.size() > 0 && $urandom_range(0, 11) == 0) begin
				drv_gap = $urandom_range(1, 6) - 1;
				push <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				push <= 1'b1;
				opcode <= cur_item.op;
				data_byte <= cur_item.data;
				last_byte <= cur_item.last;
				key_hash <= cur_item.hash;
				key_length <= cur_item.len;
				name_offset <= cur_item.off;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result side: each popped beat is compared with the oldest expected answer.
	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
		end else begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d answers outstanding",
					cycles, expected_lookups.size());
				$display("Simulation FAILED");
				$finish;
			end else begin
				if (pop && !empty) begin
					if (expected_lookups.size() == 0) begin
						errors++;
						if (errors <= 10)
							$display("%0t: unexpected result beat, status %0d hash %h",
								$realtime, status, blob_hash);
					end else begin
						want = expected_lookups.pop_front();
						checked++;
						if (want.status < 5) status_seen[want.status]++;
						if (status !== want.status || found_offset !== want.offset ||
								blob_hash !== want.hash || blob_length !== want.len) begin
							errors++;
							if (errors <= 10)
								$display({"%0t: mismatch: expected status %0d off %h hash %h ",
									"len %0d, got status %0d off %h hash %h len %0d"},
									$realtime, want.status, want.offset, want.hash, want.len,
									status, found_offset, blob_hash, blob_length);
						end
					end
				end
				if (pop_gap > 0) begin
					pop_gap--;
					pop <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					pop_gap = $urandom_range(1, 6) - 1;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	task automatic add_item(input logic [1:0] op, input logic [7:0] b, input logic last,
			input logic [63:0] h, input logic [31:0] n, input logic [31:0] off);
		item_t it;
		it.op = op;
		it.data = b;
		it.last = last;
		it.hash = h;
		it.len = n;
		it.off = off;
		pending_items.push_back(it);
		queued++;
	endtask

	// Fields that the opcode does not use carry random junk.
	task automatic add_byte(input logic [7:0] b, input logic last);
		add_item(chtl_pkg::OP_DATA, b, last, {$urandom, $urandom}, $urandom, $urandom);
	endtask

	task automatic add_pool_blob(input int p);
		for (int i = 0; i < pool_len[p]; i++)
			add_byte(pool_bytes[p][i], i == pool_len[p] - 1);
	endtask

	task automatic add_random_blob(input int n);
		for (int i = 0; i < n; i++)
			add_byte($urandom, i == n - 1);
	endtask

	task automatic add_record(input logic [63:0] h);
		add_item(chtl_pkg::OP_RECORD, $urandom, $urandom, h, $urandom, $urandom);
	endtask

	task automatic add_load(input logic [63:0] h, input logic [31:0] n, input logic [31:0] off);
		add_item(chtl_pkg::OP_LOAD, $urandom, $urandom, h, n, off);
	endtask

	// Waits until every beat is taken and every answer has come back, then lets
	// the back end settle before a register is touched.
	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() != 0 || push || expected_lookups.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_PACK) pack_on = value[0];
		else names_limit = value;
	endtask

	// Mostly well-formed lookups of known blobs, mixed with failure records,
	// odd blobs and ignored opcodes.
	task automatic random_traffic(input int count);
		int target;
		int pick;
		target = queued + count;
		while (queued < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) add_pool_blob($urandom_range(0, POOL_SIZE - 1));
			else if (pick < 78) add_random_blob($urandom_range(1, 12));
			else if (pick < 88)
				add_record(pick < 85 ? pool_hash[$urandom_range(0, POOL_SIZE - 1)]
					: {$urandom, $urandom});
			else if (pick < 94) add_item(OP_RESERVED, $urandom, $urandom,
				{$urandom, $urandom}, $urandom, $urandom);
			else add_random_blob($urandom_range(20, 40));
		end
	endtask

	initial begin
		logic [63:0] sorted_hashes[$];
		logic [31:0] len_of [logic [63:0]];
		int          decoys;
		int          real_slot;
		foreach (status_seen[i]) status_seen[i] = 0;

		for (int p = 0; p < POOL_SIZE; p++) begin
			pool_len[p] = $urandom_range(1, 6);
			pool_hash[p] = HASH_SEED;
			for (int i = 0; i < 8; i++) pool_bytes[p][i] = $urandom;
			for (int i = 0; i < pool_len[p]; i++)
				pool_hash[p] = hash_byte(pool_hash[p], pool_bytes[p][i]);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Before any register write the pack is absent; extreme bytes and an
		// ignored opcode go through.
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b0);
		add_item(OP_RESERVED, 8'hFF, 1'b1, '1, '1, '1);
		add_byte(8'h5A, 1'b1);
		drain();

		// Pack present but the table still empty.
		write_reg(ADDR_PACK, 32'h1);
		write_reg(ADDR_NAMES, 32'h0);
		add_random_blob(3);
		add_pool_blob(0);
		drain();

		// Sorted table from three quarters of the pool, each key with up to two
		// decoys of the same hash and another length.
		for (int p = 0; p < POOL_SIZE * 3 / 4; p++) begin
			sorted_hashes.push_back(pool_hash[p]);
			len_of[pool_hash[p]] = pool_len[p];
		end
		sorted_hashes.sort();
		foreach (sorted_hashes[k]) begin
			decoys = $urandom_range(0, 2);
			real_slot = $urandom_range(0, decoys);
			for (int d = 0; d <= decoys; d++) begin
				if (d == real_slot)
					add_load(sorted_hashes[k], len_of[sorted_hashes[k]], $urandom_range(0, 1999));
				else
					add_load(sorted_hashes[k], k == 0 ? 32'hFFFF_FFFF : $urandom_range(7, 1000),
						k == 1 ? 32'hFFFF_FFFF : $urandom);
			end
		end
		add_record(64'h0);
		add_record(pool_hash[1]);
		drain();

		// Every offset is out of range with a zero-sized name area.
		add_pool_blob(1);
		add_pool_blob(2);
		drain();
		write_reg(ADDR_NAMES, 32'd1000);
		for (int p = 0; p < 6; p++) add_pool_blob(p);
		random_traffic(300);
		drain();

		write_reg(ADDR_NAMES, 32'hFFFF_FFFF);
		random_traffic(150);
		drain();

		write_reg(ADDR_PACK, 32'h0);
		random_traffic(30);
		drain();

		// Unsorted tail: a low hash appended after the high ones.
		write_reg(ADDR_PACK, 32'h1);
		write_reg(ADDR_NAMES, 32'd1000);
		add_load(pool_hash[POOL_SIZE - 1], pool_len[POOL_SIZE - 1], 32'd7);
		add_load(64'h0, 32'd1, 32'd3);
		add_pool_blob(POOL_SIZE - 1);
		random_traffic(60);
		drain();

		// One more load after the unsorted tail.
		add_load(pool_hash[POOL_SIZE - 2], pool_len[POOL_SIZE - 2], 32'd9);
		random_traffic(40);
		drain();

		// Last part without idling: more failure records, then a few lookups
		// that walk the whole list.
		quiet = 1'b1;
		for (int i = 0; i < 20; i++)
			add_record({$urandom, $urandom});
		add_record(pool_hash[3]);
		for (int p = 3; p < 8; p++) add_pool_blob(p);

		do @(negedge clk);
		while (pending_items.size() != 0 || push || expected_lookups.size() != 0);
		repeat (60) @(posedge clk);

		$display("Checked %0d lookup answers from %0d beats, table %0d, failed list %0d.",
			checked, queued, tbl_count, failed_count);
		$display("Answers: hit %0d, unavailable %0d, no match %0d, offset range %0d, failed %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (errors == 0 && expected_lookups.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d answers missing", errors, expected_lookups.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
